### hdl/rhe_pkg.sv
// Shared types and constants for the RGB histogram equalizer.
`default_nettype none
package rhe_pkg;

  localparam int IN_CH = 3;
  localparam int BIN_W = 25;
  localparam int REG_W = 13;
  localparam int TOTAL_W = 2 * REG_W;
  localparam int DEN_W = TOTAL_W + 1;
  localparam int NUM_W = BIN_W + 10;
  localparam int LVL_W = 8;
  localparam int STEP_W = 3;

  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};
  localparam logic [LVL_W-1:0] MAX_LEVEL = 8'd255;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_COUNT = 2'd1;
  localparam logic [1:0] ACT_FINAL = 2'd2;
  localparam logic [1:0] ACT_MAP = 2'd3;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [1:0] WM_ZERO = 2'd0;
  localparam logic [1:0] WM_INC = 2'd1;
  localparam logic [1:0] WM_ACC = 2'd2;

  typedef struct packed {
    logic cap;
    logic use_pix;
    logic rd;
    logic wr;
    logic [1:0] wmode;
    logic acc_ld;
    logic div_start;
    logic div_step;
    logic [STEP_W-1:0] shift;
  } rhe_ctrl_t;

endpackage
`default_nettype wire

### hdl/rhe_lane.sv
// One channel lane: bin memory, saturating update and level divider.
`default_nettype none
module rhe_lane
  import rhe_pkg::*;
#(
  parameter int BINS = 256,
  parameter int IW = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rhe_ctrl_t          ctrl_i,
  input  wire logic [IW-1:0]      cnt_i,
  input  wire logic [LVL_W-1:0]   pix_i,
  input  wire logic [TOTAL_W-1:0] total_i,
  output logic [LVL_W-1:0]        level_o
);

  logic [BIN_W-1:0] mem [BINS];
  logic [BIN_W-1:0] rdata_q;
  logic [BIN_W-1:0] acc_q;
  logic [IW-1:0]    pix_q;
  logic [IW-1:0]    pix_idx;
  logic [IW-1:0]    addr;
  logic [BIN_W-1:0] wdata;
  logic [BIN_W:0]   sum;
  logic [NUM_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [LVL_W-1:0] q_q;
  logic             done_q;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] trial;

  always_comb begin
    if ({24'd0, pix_i} >= 32'(BINS)) begin
      pix_idx = IW'(BINS - 1);
    end else begin
      pix_idx = IW'(pix_i);
    end
  end

  assign addr = ctrl_i.use_pix ? pix_q : cnt_i;
  assign sum = {1'b0, acc_q} + {1'b0, rdata_q};

  always_comb begin
    case (ctrl_i.wmode)
      WM_INC:  wdata = (rdata_q == BIN_MAX) ? rdata_q : rdata_q + 1'b1;
      WM_ACC:  wdata = sum[BIN_W] ? BIN_MAX : sum[BIN_W-1:0];
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem[addr] <= wdata;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      pix_q <= pix_idx;
    end
    if (ctrl_i.acc_ld) begin
      acc_q <= rdata_q;
    end else if (ctrl_i.wr && ctrl_i.wmode == WM_ACC) begin
      acc_q <= wdata;
    end
  end

  assign num = ({rdata_q, 10'd0} >> 1) - NUM_W'({rdata_q, 1'b0}) + NUM_W'(total_i);
  assign den = {total_i, 1'b0};
  assign trial = NUM_W'(den_q) << ctrl_i.shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b1;
      q_q <= '0;
    end else if (ctrl_i.div_start) begin
      if (total_i == '0) begin
        done_q <= 1'b1;
        q_q <= '0;
      end else if (num >= (NUM_W'(den) << 8)) begin
        done_q <= 1'b1;
        q_q <= MAX_LEVEL;
      end else begin
        done_q <= 1'b0;
        q_q <= '0;
      end
    end else if (ctrl_i.div_step && !done_q && rem_q >= trial) begin
      q_q[ctrl_i.shift] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      rem_q <= num;
      den_q <= den;
    end else if (ctrl_i.div_step && rem_q >= trial) begin
      rem_q <= rem_q - trial;
    end
  end

  assign level_o = q_q;

endmodule
`default_nettype wire

### hdl/rgb_histogram_equalizer_unit.sv
// Four actions: clear, count, finalize and map; map uses an 8-step divider.
// One item at a time; the next is taken once the current one finishes.
// A map result waits in an output register while the next item is taken.
// After reset the bins are swept to zero before input is taken.
// Each of the first IN_CH lanes works on its own channel in parallel.
`default_nettype none
module rgb_histogram_equalizer_unit
  import rhe_pkg::*;
#(
  parameter int BINS = 256,
  parameter int CHANNELS = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [REG_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       action_i,
  input  wire logic [7:0]       channel_0_i,
  input  wire logic [7:0]       channel_1_i,
  input  wire logic [7:0]       channel_2_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            out_0_o,
  output logic [7:0]            out_1_o,
  output logic [7:0]            out_2_o
);

  localparam int IW = $clog2(BINS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR = 4'd1;
  localparam logic [3:0] S_CNT_RD = 4'd2;
  localparam logic [3:0] S_CNT_WR = 4'd3;
  localparam logic [3:0] S_FIN_RD0 = 4'd4;
  localparam logic [3:0] S_FIN_A = 4'd5;
  localparam logic [3:0] S_FIN_RD = 4'd6;
  localparam logic [3:0] S_FIN_WR = 4'd7;
  localparam logic [3:0] S_MAP_RD = 4'd8;
  localparam logic [3:0] S_MAP_LD = 4'd9;
  localparam logic [3:0] S_MAP_DIV = 4'd10;
  localparam logic [3:0] S_MAP_OUT = 4'd11;

  logic [3:0]         state_q, state_d;
  logic [IW-1:0]      cnt_q, cnt_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [REG_W-1:0]   width_q, height_q;
  logic [TOTAL_W-1:0] total_q;
  rhe_ctrl_t          ctrl;
  logic               in_xfer;
  logic               out_free;
  logic               out_load;
  logic               out_valid_q;
  logic [IN_CH-1:0][7:0] chan;
  logic [IN_CH-1:0][7:0] level;
  logic [IN_CH-1:0][7:0] out_q;

  assign chan = {channel_2_i, channel_1_i, channel_0_i};
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_MAP_OUT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= REG_W'(512);
      height_q <= REG_W'(512);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_FRAME_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= width_q * height_q;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    step_d = step_q;
    ctrl = '0;
    unique case (state_q)
      S_IDLE: begin
        ctrl.cap = in_xfer;
        if (in_xfer) begin
          cnt_d = '0;
          case (action_i)
            ACT_CLEAR: state_d = S_CLR;
            ACT_COUNT: state_d = S_CNT_RD;
            ACT_FINAL: state_d = S_FIN_RD0;
            default:   state_d = S_MAP_RD;
          endcase
        end
      end
      S_CLR: begin
        ctrl.wr = 1'b1;
        ctrl.wmode = WM_ZERO;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IW'(BINS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_CNT_RD: begin
        ctrl.use_pix = 1'b1;
        ctrl.rd = 1'b1;
        state_d = S_CNT_WR;
      end
      S_CNT_WR: begin
        ctrl.use_pix = 1'b1;
        ctrl.wr = 1'b1;
        ctrl.wmode = WM_INC;
        state_d = S_IDLE;
      end
      S_FIN_RD0: begin
        ctrl.rd = 1'b1;
        cnt_d = IW'(1);
        state_d = S_FIN_A;
      end
      S_FIN_A: begin
        ctrl.acc_ld = 1'b1;
        ctrl.rd = 1'b1;
        state_d = S_FIN_WR;
      end
      S_FIN_RD: begin
        ctrl.rd = 1'b1;
        state_d = S_FIN_WR;
      end
      S_FIN_WR: begin
        ctrl.wr = 1'b1;
        ctrl.wmode = WM_ACC;
        cnt_d = cnt_q + 1'b1;
        state_d = (cnt_q == IW'(BINS - 1)) ? S_IDLE : S_FIN_RD;
      end
      S_MAP_RD: begin
        ctrl.use_pix = 1'b1;
        ctrl.rd = 1'b1;
        state_d = S_MAP_LD;
      end
      S_MAP_LD: begin
        ctrl.div_start = 1'b1;
        step_d = '1;
        state_d = S_MAP_DIV;
      end
      S_MAP_DIV: begin
        ctrl.div_step = 1'b1;
        ctrl.shift = step_q;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = S_MAP_OUT;
        end
      end
      S_MAP_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q <= '0;
      step_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      step_q <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    rhe_ctrl_t     lane_ctrl;
    logic [7:0]    lane_pix;
    logic [7:0]    lane_level;
    always_comb begin
      lane_ctrl = ctrl;
      if (k >= IN_CH && ctrl.wmode == WM_INC) begin
        lane_ctrl.wr = 1'b0;
      end
    end
    if (k < IN_CH) begin : g_in
      assign lane_pix = chan[k];
      assign level[k] = lane_level;
    end else begin : g_extra
      assign lane_pix = 8'd0;
    end
    rhe_lane #(
      .BINS(BINS),
      .IW  (IW)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .cnt_i  (cnt_q),
      .pix_i  (lane_pix),
      .total_i(total_q),
      .level_o(lane_level)
    );
  end

  for (genvar k = CHANNELS; k < IN_CH; k++) begin : g_off
    assign level[k] = 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= level;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_0_o = out_q[0];
  assign out_1_o = out_q[1];
  assign out_2_o = out_q[2];

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == S_IDLE)
    else $error("input taken outside idle");
  a_out_from_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_MAP_OUT)
    else $error("result not from map");
  a_clr_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR && cnt_q == IW'(BINS - 1) |=> state_q == S_IDLE)
    else $error("clear sweep overrun");

endmodule
`default_nettype wire

### dv/tb_rgb_histogram_equalizer_unit.sv
// Testbench for rgb_histogram_equalizer_unit: directed table plus random frames.
`default_nettype none
module tb_rgb_histogram_equalizer_unit;
  import rhe_pkg::*;

  localparam int NBINS = 256;
  localparam int LIMIT = 3000000;
  localparam int SETTLE = 2 * NBINS + 64;
  localparam int ITEMS = 1300;

  typedef struct packed {
    logic             wr_cfg;
    logic [REG_W-1:0] w;
    logic [REG_W-1:0] h;
    logic [1:0]       act;
    logic [7:0]       c0, c1, c2;
    logic             fixed;
    logic [7:0]       e0, e1, e2;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] o0, o1, o2;
  } pix_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_FRAME_WIDTH;
  logic [REG_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [1:0]       action_i = ACT_CLEAR;
  logic [7:0]       channel_0_i = '0, channel_1_i = '0, channel_2_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       out_0_o, out_1_o, out_2_o;

  rgb_histogram_equalizer_unit i_dut (.*);

  logic [BIN_W-1:0] hist_q [IN_CH][NBINS];
  logic [REG_W-1:0] width_q, height_q;
  pix_t             pending_q[$];
  int               errors = 0;
  int               cycles = 0;
  int               sent = 0;
  int               hold = 0;
  bit               hold_done = 1'b0;

  dir_row_t dir_tab[18] = '{
    '{1'b0, 13'd0, 13'd0, ACT_MAP, 8'd0, 8'd128, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_COUNT, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_COUNT, 8'd255, 8'd128, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_COUNT, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_FINAL, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_MAP, 8'd0, 8'd128, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_MAP, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b1, 13'd1, 13'd1, ACT_MAP, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{1'b1, 13'd0, 13'd512, ACT_MAP, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0},
    '{1'b1, 13'd512, 13'd0, ACT_MAP, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0},
    '{1'b1, 13'd8191, 13'd8191, ACT_MAP, 8'd255, 8'd0, 8'd128, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b1, 13'd4096, 13'd4096, ACT_MAP, 8'd255, 8'd0, 8'd128, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b1, 13'd3, 13'd1, ACT_FINAL, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_MAP, 8'd1, 8'd127, 8'd254, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_MAP, 8'd10, 8'd20, 8'd30, 1'b1, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_COUNT, 8'd7, 8'd7, 8'd7, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 13'd0, 13'd0, ACT_MAP, 8'd6, 8'd7, 8'd200, 1'b0, 8'd0, 8'd0, 8'd0}
  };

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [BIN_W-1:0] sat_sum(logic [BIN_W-1:0] a, logic [BIN_W-1:0] b);
    logic [BIN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BIN_W] ? BIN_MAX : s[BIN_W-1:0];
  endfunction

  function automatic logic [7:0] level_of(logic [BIN_W-1:0] cum);
    logic [63:0] total, q;
    total = 64'(width_q) * 64'(height_q);
    if (total == 0) return 8'd0;
    q = (64'(cum) * 510 + total) / (2 * total);
    return (q > 255) ? MAX_LEVEL : q[7:0];
  endfunction

  // Returns 1 when the action yields a pixel.
  function automatic bit equalize_step(logic [1:0] act, logic [7:0] v0, logic [7:0] v1,
                                       logic [7:0] v2, output pix_t px);
    logic [7:0] v [IN_CH];
    v[0] = v0; v[1] = v1; v[2] = v2;
    px = '0;
    case (act)
      ACT_CLEAR: begin
        foreach (hist_q[k, b]) hist_q[k][b] = '0;
      end
      ACT_COUNT: begin
        for (int k = 0; k < IN_CH; k++)
          hist_q[k][v[k]] = sat_sum(hist_q[k][v[k]], BIN_W'(1));
      end
      ACT_FINAL: begin
        for (int k = 0; k < IN_CH; k++)
          for (int b = 1; b < NBINS; b++) hist_q[k][b] = sat_sum(hist_q[k][b-1], hist_q[k][b]);
      end
      default: begin
        px.o0 = level_of(hist_q[0][v0]);
        px.o1 = level_of(hist_q[1][v1]);
        px.o2 = level_of(hist_q[2][v2]);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_frame(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
    drain_and_settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_FRAME_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= REG_FRAME_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_q = w;
    height_q = h;
  endtask

  task automatic send_pixel(logic [1:0] act, logic [7:0] v0, logic [7:0] v1, logic [7:0] v2,
                            bit fixed = 0, pix_t want = '0);
    pix_t px;
    if (!(sent >= 400 && sent < 600) && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    channel_0_i <= v0;
    channel_1_i <= v1;
    channel_2_i <= v2;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    if (equalize_step(act, v0, v1, v2, px)) pending_q.push_back(fixed ? want : px);
  endtask

  task automatic send_random_pixel(logic [1:0] act);
    send_pixel(act, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off, and a quiet window.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer %h %h %h", out_0_o, out_1_o, out_2_o);
      end else begin
        if ({out_0_o, out_1_o, out_2_o} != pending_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %h %h %h got %h %h %h", pending_q[0].o0, pending_q[0].o1,
                     pending_q[0].o2, out_0_o, out_1_o, out_2_o);
        end
        void'(pending_q.pop_front());
      end
    end
    if (hold > 0) begin
      hold <= hold - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && cycles > 4000 && out_valid_o) begin
      hold_done <= 1'b1;
      hold <= 400;
      out_stall_i <= 1'b1;
    end else if (cycles > 20000 && cycles < 40000) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 32);
    end
  end

  initial begin
    int n;
    width_q = 13'd512;
    height_q = 13'd512;
    foreach (hist_q[k, b]) hist_q[k][b] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_cfg) set_frame(dir_tab[i].w, dir_tab[i].h);
      send_pixel(dir_tab[i].act, dir_tab[i].c0, dir_tab[i].c1, dir_tab[i].c2, dir_tab[i].fixed,
                 {dir_tab[i].e0, dir_tab[i].e1, dir_tab[i].e2});
    end
    while (sent < ITEMS) begin
      case ($urandom_range(7))
        0: set_frame(13'd1, 13'd1);
        1: set_frame(13'd8191, 13'($urandom_range(8191)));
        2: set_frame(13'd0, 13'($urandom_range(8191)));
        3: set_frame(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)));
        default: set_frame(13'($urandom_range(8, 1)), 13'($urandom_range(8, 1)));
      endcase
      if ($urandom_range(9) < 8) send_pixel(ACT_CLEAR, 8'($urandom_range(255)), 8'd0, 8'd0);
      n = $urandom_range(60, 5);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) send_random_pixel(2'($urandom_range(3)));
        else if ($urandom_range(3) == 0)
          send_pixel(ACT_COUNT, 8'($urandom_range(15)), 8'($urandom_range(255, 240)),
                     8'($urandom_range(255)));
        else send_random_pixel(ACT_COUNT);
      end
      n = ($urandom_range(4) == 0) ? $urandom_range(6, 2) : 1;
      for (int i = 0; i < n; i++) send_random_pixel(ACT_FINAL);
      n = $urandom_range(40, 10);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) send_random_pixel(2'($urandom_range(3)));
        else send_random_pixel(ACT_MAP);
      end
    end
    drain_and_settle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
